// ----- src/pfn_pkg.sv -----
// pfn_pkg: shared widths and the queue entry type for the polygon face normal core.
// No dependencies.
`timescale 1ns / 1ps
package pfn_pkg;
   localparam int CfgWidth      = 40;
   localparam int NrmWidth      = 16;
   localparam int DefMaxVerts   = 256;
   localparam int DefPosWidth   = 24;
   localparam logic [CfgWidth-1:0] CfgReset = 40'd1126;
   localparam int SumWidth      = 60;
   localparam int CrossWidth    = 52;
   localparam int FracDivBits   = 16;

   typedef struct packed {
      logic signed [DefPosWidth-1:0] x;
      logic signed [DefPosWidth-1:0] y;
      logic signed [DefPosWidth-1:0] z;
      logic                          first;   // opens a polygon
      logic                          tri_ok;  // forms a fan triangle
      logic                          take;    // vertex within the count limit
      logic                          last;
      logic                          too_few;
      logic                          too_many;
   } pfn_entry_type;
endpackage

// ----- src/pfn_front.sv -----
// pfn_front: accepts vertices, counts them per polygon and classifies each.
// Depends on pfn_pkg.
`timescale 1ns / 1ps
module pfn_front #(
   parameter int MAX_VERTICES = pfn_pkg::DefMaxVerts,
   parameter int POS_WIDTH    = pfn_pkg::DefPosWidth
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_stall,
   input  logic [POS_WIDTH-1:0]        in_x,
   input  logic [POS_WIDTH-1:0]        in_y,
   input  logic [POS_WIDTH-1:0]        in_z,
   input  logic                        in_last,
   output logic                        q_valid,
   input  logic                        q_stall,
   output pfn_pkg::pfn_entry_type      q_entry
);
   import pfn_pkg::*;
   localparam int CntW = $clog2(MAX_VERTICES + 2);

   logic [CntW-1:0] count_ff, count_in, cnt_new;
   logic            acc;
   pfn_entry_type   ent;

   // two-entry queue
   pfn_entry_type   q_ff [2];
   logic [1:0]      fill_ff;
   logic            rd_ptr_ff, wr_ptr_ff;

   assign in_stall = (fill_ff == 2'd2);
   assign acc      = in_valid && !in_stall;

   always_comb begin
      ent.x = DefPosWidth'($signed(in_x));
      ent.y = DefPosWidth'($signed(in_y));
      ent.z = DefPosWidth'($signed(in_z));
      ent.take   = (count_ff < CntW'(MAX_VERTICES));
      ent.first  = (count_ff == '0);
      ent.tri_ok = ent.take && (count_ff >= CntW'(2));
      ent.last   = in_last;
      cnt_new    = ent.take ? count_ff + 1'b1 : CntW'(MAX_VERTICES + 1);
      ent.too_few  = (cnt_new < CntW'(3));
      ent.too_many = (cnt_new > CntW'(MAX_VERTICES));
      count_in = count_ff;
      if (acc) count_in = in_last ? '0 : cnt_new;
   end

   assign q_valid = (fill_ff != 2'd0);
   assign q_entry = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         fill_ff   <= '0;
         rd_ptr_ff <= 1'b0;
         wr_ptr_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (acc) wr_ptr_ff <= !wr_ptr_ff;
         if (q_valid && !q_stall) rd_ptr_ff <= !rd_ptr_ff;
         fill_ff <= fill_ff + {1'b0, acc} - {1'b0, q_valid && !q_stall};
      end
      if (acc) q_ff[wr_ptr_ff] <= ent;
   end
endmodule

// ----- src/pfn_back.sv -----
// pfn_back: fan cross product accumulation and normalisation sequencer.
// Depends on pfn_pkg.
`timescale 1ns / 1ps
module pfn_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [pfn_pkg::CfgWidth-1:0]   min_cross_sq,
   input  logic                           q_valid,
   output logic                           q_stall,
   input  pfn_pkg::pfn_entry_type         q_entry,
   output logic                           out_valid,
   input  logic                           out_stall,
   output logic [pfn_pkg::NrmWidth-1:0]   out_nx,
   output logic [pfn_pkg::NrmWidth-1:0]   out_ny,
   output logic [pfn_pkg::NrmWidth-1:0]   out_nz,
   output logic                           out_visible,
   output logic                           out_too_few,
   output logic                           out_too_many
);
   import pfn_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MUL0, S_MUL1, S_ACC, S_SHIFT, S_SQ, S_SQRT, S_DIV, S_OUT
   } state_type;

   state_type state_ff;
   logic signed [DefPosWidth-1:0] fst_ff [3];
   logic signed [DefPosWidth-1:0] prv_ff [3];
   logic signed [DefPosWidth-1:0] cur_ff [3];
   logic signed [SumWidth-1:0]    sum_ff [3];
   logic signed [DefPosWidth:0]   ea_ff [3], eb_ff [3];
   logic signed [CrossWidth-1:0]  pa_ff [3], pb_ff [3];
   logic                          vis_ff, last_ff, few_ff, many_ff, tri_ff;
   logic [1:0]                    k_ff;
   logic [SumWidth-1:0]           mag_ff [3];
   logic [63:0]                   q_ff, rem_ff, root_ff, bit_ff;
   logic [5:0]                    it_ff;
   logic [47:0]                   dnum_ff, drem_ff;
   logic [31:0]                   den_ff;
   logic [15:0]                   quo_ff;
   logic [NrmWidth-1:0]           nrm_ff [3];
   logic                          ov_ff;

   logic signed [CrossWidth-1:0] cr [3];
   logic [CrossWidth-1:0]        cm [3];
   logic [41:0]                  sq;
   logic                         big;
   logic [SumWidth-1:0]          mx;

   assign q_stall = (state_ff != S_IDLE);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         cr[k] = pa_ff[k] - pb_ff[k];
         cm[k] = cr[k][CrossWidth-1] ? CrossWidth'(-cr[k]) : CrossWidth'(cr[k]);
      end
      big = 1'b0;
      sq  = '0;
      for (int k = 0; k < 3; k++) begin
         if (cm[k] >= CrossWidth'(1 << 20)) big = 1'b1;
         else sq = sq + 42'(cm[k][19:0] * cm[k][19:0]);
      end
      mx = mag_ff[0];
      if (mag_ff[1] > mx) mx = mag_ff[1];
      if (mag_ff[2] > mx) mx = mag_ff[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ov_ff    <= 1'b0;
         vis_ff   <= 1'b0;
         for (int k = 0; k < 3; k++) begin
            sum_ff[k] <= '0;
            fst_ff[k] <= '0;
            prv_ff[k] <= '0;
         end
      end else begin
         if (ov_ff && !out_stall) ov_ff <= 1'b0;
         case (state_ff)
            S_IDLE: begin
               if (q_valid) begin
                  cur_ff[0] <= q_entry.x;
                  cur_ff[1] <= q_entry.y;
                  cur_ff[2] <= q_entry.z;
                  if (q_entry.take) begin
                     prv_ff[0] <= q_entry.x;
                     prv_ff[1] <= q_entry.y;
                     prv_ff[2] <= q_entry.z;
                     if (q_entry.first) begin
                        fst_ff[0] <= q_entry.x;
                        fst_ff[1] <= q_entry.y;
                        fst_ff[2] <= q_entry.z;
                     end
                  end
                  tri_ff  <= q_entry.tri_ok;
                  last_ff <= q_entry.last;
                  few_ff  <= q_entry.too_few;
                  many_ff <= q_entry.too_many;
                  for (int k = 0; k < 3; k++)
                     ea_ff[k] <= (DefPosWidth+1)'(prv_ff[k]) - (DefPosWidth+1)'(fst_ff[k]);
                  state_ff <= S_MUL0;
               end
            end
            S_MUL0: begin
               // edge to the current vertex
               for (int k = 0; k < 3; k++)
                  eb_ff[k] <= (DefPosWidth+1)'(cur_ff[k]) - (DefPosWidth+1)'(fst_ff[k]);
               state_ff <= S_MUL1;
            end
            S_MUL1: begin
               pa_ff[0] <= CrossWidth'(ea_ff[1] * eb_ff[2]);
               pb_ff[0] <= CrossWidth'(ea_ff[2] * eb_ff[1]);
               pa_ff[1] <= CrossWidth'(ea_ff[2] * eb_ff[0]);
               pb_ff[1] <= CrossWidth'(ea_ff[0] * eb_ff[2]);
               pa_ff[2] <= CrossWidth'(ea_ff[0] * eb_ff[1]);
               pb_ff[2] <= CrossWidth'(ea_ff[1] * eb_ff[0]);
               state_ff <= S_ACC;
            end
            S_ACC: begin
               logic signed [SumWidth-1:0] ns [3];
               for (int k = 0; k < 3; k++) begin
                  ns[k] = sum_ff[k] + (tri_ff ? SumWidth'(cr[k]) : '0);
                  sum_ff[k] <= ns[k];
                  mag_ff[k] <= ns[k][SumWidth-1] ? SumWidth'(-ns[k]) : SumWidth'(ns[k]);
               end
               if (tri_ff && (big || {2'b0, sq} > {2'b0, min_cross_sq})) vis_ff <= 1'b1;
               state_ff <= last_ff ? S_SHIFT : S_IDLE;
            end
            S_SHIFT: begin
               // one bit a cycle until the largest magnitude fits in 30 bits
               if (mx >= SumWidth'(64'd1 << 30)) begin
                  for (int k = 0; k < 3; k++) mag_ff[k] <= mag_ff[k] >> 1;
               end else begin
                  q_ff  <= '0;
                  k_ff  <= 2'd0;
                  state_ff <= S_SQ;
               end
            end
            S_SQ: begin
               q_ff <= q_ff + 64'(mag_ff[k_ff][29:0] * mag_ff[k_ff][29:0]);
               if (k_ff == 2'd2) begin
                  state_ff <= S_SQRT;
                  bit_ff   <= 64'd1 << 62;
                  root_ff  <= '0;
               end else k_ff <= k_ff + 1'b1;
               rem_ff <= '0;
            end
            S_SQRT: begin
               if (k_ff == 2'd2) begin
                  rem_ff <= q_ff;
                  k_ff   <= 2'd0;
               end else if (bit_ff != 0) begin
                  if (rem_ff >= root_ff + bit_ff) begin
                     rem_ff  <= rem_ff - (root_ff + bit_ff);
                     root_ff <= (root_ff >> 1) + bit_ff;
                  end else root_ff <= root_ff >> 1;
                  bit_ff <= bit_ff >> 2;
               end else begin
                  den_ff   <= 32'(root_ff) << 1;
                  dnum_ff  <= 48'(mag_ff[0][29:0]) * 48'd32768 + 48'(root_ff[31:0]);
                  drem_ff  <= '0;
                  quo_ff   <= '0;
                  it_ff    <= 6'd0;
                  k_ff     <= 2'd0;
                  state_ff <= (mx == '0) ? S_OUT : S_DIV;
                  for (int k = 0; k < 3; k++) nrm_ff[k] <= '0;
               end
            end
            S_DIV: begin
               // restoring divide, one quotient bit a cycle
               logic [48:0] tr;
               logic [15:0] qn;
               tr = {drem_ff, dnum_ff[47]};
               qn = {quo_ff[14:0], 1'b0};
               if (tr >= 49'(den_ff)) begin
                  tr = tr - 49'(den_ff);
                  qn[0] = 1'b1;
               end
               drem_ff <= tr[47:0];
               dnum_ff <= dnum_ff << 1;
               quo_ff  <= qn;
               if (it_ff == 6'd47) begin
                  nrm_ff[k_ff] <= sum_ff[k_ff] > 0 ? NrmWidth'(-qn) : qn;
                  it_ff   <= 6'd0;
                  drem_ff <= '0;
                  if (k_ff == 2'd2) state_ff <= S_OUT;
                  else begin
                     k_ff    <= k_ff + 1'b1;
                     dnum_ff <= 48'(mag_ff[k_ff + 1'b1][29:0]) * 48'd32768
                                + 48'(root_ff[31:0]);
                  end
               end else it_ff <= it_ff + 1'b1;
            end
            S_OUT: begin
               // hold while the previous item still waits in the result register
               if (!ov_ff || !out_stall) begin
                  out_nx       <= nrm_ff[0];
                  out_ny       <= nrm_ff[1];
                  out_nz       <= nrm_ff[2];
                  out_visible  <= vis_ff;
                  out_too_few  <= few_ff;
                  out_too_many <= many_ff;
                  ov_ff        <= 1'b1;
                  vis_ff       <= 1'b0;
                  for (int k = 0; k < 3; k++) sum_ff[k] <= '0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign out_valid = ov_ff;
endmodule

// ----- src/polygon_face_normal_core.sv -----
// Channel | ports                         | direction
// req     | req_valid/req_stall, pos, last | in
// rsp     | rsp_valid/rsp_stall, normal    | out
// csr     | csr_we/csr_wdata               | in
// In the back end a vertex passes the capture, edge, multiply and accumulate states.
// The last vertex then adds shifting, squaring, a square root and one restoring divide
// per axis of the normal before the result goes out.
// A waiting result holds the back end only once the next result is ready.
// Reset is synchronous; a two-entry queue decouples vertex intake from the back end.
`timescale 1ns / 1ps
module polygon_face_normal_core #(
   parameter int MAX_VERTICES = pfn_pkg::DefMaxVerts,
   parameter int POS_WIDTH    = pfn_pkg::DefPosWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [POS_WIDTH-1:0]         req_pos_x,
   input  logic [POS_WIDTH-1:0]         req_pos_y,
   input  logic [POS_WIDTH-1:0]         req_pos_z,
   input  logic                         req_last_vertex,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [pfn_pkg::NrmWidth-1:0] rsp_normal_x,
   output logic [pfn_pkg::NrmWidth-1:0] rsp_normal_y,
   output logic [pfn_pkg::NrmWidth-1:0] rsp_normal_z,
   output logic                         rsp_visible,
   output logic                         rsp_too_few,
   output logic                         rsp_too_many,
   input  logic                         csr_we,
   input  logic [pfn_pkg::CfgWidth-1:0] csr_wdata
);
   import pfn_pkg::*;

   logic [CfgWidth-1:0] thr_ff;
   logic                q_valid, q_stall;
   pfn_entry_type       q_entry;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= CfgReset;
      else if (csr_we) thr_ff <= csr_wdata;
   end

   pfn_front #(.MAX_VERTICES(MAX_VERTICES), .POS_WIDTH(POS_WIDTH)) u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_stall(req_stall),
      .in_x(req_pos_x), .in_y(req_pos_y), .in_z(req_pos_z),
      .in_last(req_last_vertex),
      .q_valid, .q_stall, .q_entry
   );

   pfn_back u_back (
      .clock, .reset, .min_cross_sq(thr_ff),
      .q_valid, .q_stall, .q_entry,
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .out_nx(rsp_normal_x), .out_ny(rsp_normal_y), .out_nz(rsp_normal_z),
      .out_visible(rsp_visible), .out_too_few(rsp_too_few),
      .out_too_many(rsp_too_many)
   );

   a_few_many: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_too_few && rsp_too_many))
      else $error("too_few and too_many together");
   a_few_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_too_few) |-> (!rsp_visible && rsp_normal_x == '0))
      else $error("short polygon with non-zero result");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid)
      else $error("result dropped under stall");
endmodule

// ----- test/polygon_face_normal_core_tb.sv -----
// Self-checking testbench for polygon_face_normal_core: streams polygons of vertices,
// predicts each face normal in a model of its own or takes it from the directed table, and compares every result item.
// Depends on pfn_pkg and polygon_face_normal_core.
`timescale 1ns / 1ps
module polygon_face_normal_core_tb;
   import pfn_pkg::*;

   localparam int PosW      = DefPosWidth;
   localparam int MaxVerts  = DefMaxVerts;
   localparam int SettleCyc = 400;
   localparam int HoldCyc   = 1500;
   localparam logic [CfgWidth-1:0] ThrMax = {CfgWidth{1'b1}};

   typedef struct {
      logic [NrmWidth-1:0] nx, ny, nz;
      bit                  vis, few, many;
   } face_normal_type;

   typedef struct {
      logic [PosW-1:0] x, y, z;
      bit              last;
      bit              typed;
      face_normal_type res;
   } vertex_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [PosW-1:0]     req_pos_x = '0, req_pos_y = '0, req_pos_z = '0;
   logic                req_last_vertex = 1'b0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [NrmWidth-1:0] rsp_normal_x, rsp_normal_y, rsp_normal_z;
   logic                rsp_visible, rsp_too_few, rsp_too_many;
   logic                csr_we = 1'b0;
   logic [CfgWidth-1:0] csr_wdata = '0;

   // predictor state
   logic [CfgWidth-1:0] threshold;
   longint              first_v[3], prev_v[3], fan_sum[3];
   int                  vert_count;
   bit                  seen_visible;

   face_normal_type     pending_normals[$];
   int                  errors = 0;
   int                  idle_pct = 0, stall_pct = 0;
   bit                  hold_off = 1'b0;

   polygon_face_normal_core DUT (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("Mismatches found");
      $finish;
   end

   // receiver: random stalls, plus one long hold when asked
   initial begin
      forever begin
         @(posedge clock);
         if (hold_off) begin
            rsp_stall <= 1'b1;
            repeat (HoldCyc) @(posedge clock);
            hold_off = 1'b0;
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      face_normal_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_normals.size() == 0) begin
            $error("unexpected result item");
            errors++;
         end else begin
            want = pending_normals.pop_front();
            if (rsp_normal_x !== want.nx) begin
               $error("normal_x exp %0d got %0d", $signed(want.nx), $signed(rsp_normal_x));
               errors++;
            end
            if (rsp_normal_y !== want.ny) begin
               $error("normal_y exp %0d got %0d", $signed(want.ny), $signed(rsp_normal_y));
               errors++;
            end
            if (rsp_normal_z !== want.nz) begin
               $error("normal_z exp %0d got %0d", $signed(want.nz), $signed(rsp_normal_z));
               errors++;
            end
            if (rsp_visible !== want.vis) begin
               $error("visible exp %0d got %0d", want.vis, rsp_visible);
               errors++;
            end
            if (rsp_too_few !== want.few) begin
               $error("too_few exp %0d got %0d", want.few, rsp_too_few);
               errors++;
            end
            if (rsp_too_many !== want.many) begin
               $error("too_many exp %0d got %0d", want.many, rsp_too_many);
               errors++;
            end
         end
      end
   end

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v -= r + b;
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint unsigned magnitude(longint v);
      return (v < 0) ? longint'(-v) : v;
   endfunction

   function automatic void clear_polygon();
      for (int k = 0; k < 3; k++) fan_sum[k] = 0;
      vert_count   = 0;
      seen_visible = 1'b0;
   endfunction

   function automatic void add_fan_triangle(longint cur[3]);
      longint          ea[3], eb[3], c[3];
      longint unsigned m, sq;
      bit              big;
      sq  = 0;
      big = 1'b0;
      for (int k = 0; k < 3; k++) begin
         ea[k] = prev_v[k] - first_v[k];
         eb[k] = cur[k] - first_v[k];
      end
      c[0] = ea[1] * eb[2] - ea[2] * eb[1];
      c[1] = ea[2] * eb[0] - ea[0] * eb[2];
      c[2] = ea[0] * eb[1] - ea[1] * eb[0];
      for (int k = 0; k < 3; k++) begin
         m = magnitude(c[k]);
         fan_sum[k] += c[k];
         if (m >= (64'd1 << 20)) big = 1'b1;
         else sq += m * m;
      end
      if (big || sq > threshold) seen_visible = 1'b1;
   endfunction

   // advance the polygon by one vertex; returns 1 with the normal on the last one
   function automatic bit predict_vertex(logic [PosW-1:0] px, logic [PosW-1:0] py,
                                         logic [PosW-1:0] pz, bit last,
                                         output face_normal_type res);
      longint          cur[3];
      longint unsigned a[3], mx, q, len, r;
      int              sh;
      cur[0] = longint'($signed(px));
      cur[1] = longint'($signed(py));
      cur[2] = longint'($signed(pz));
      if (vert_count < MaxVerts) begin
         if (vert_count == 0) first_v = cur;
         else if (vert_count >= 2) add_fan_triangle(cur);
         prev_v = cur;
         vert_count++;
      end else begin
         vert_count = MaxVerts + 1;
      end
      if (!last) return 1'b0;
      mx = 0;
      for (int k = 0; k < 3; k++) begin
         a[k] = magnitude(fan_sum[k]);
         if (a[k] > mx) mx = a[k];
      end
      res.nx = '0;
      res.ny = '0;
      res.nz = '0;
      if (mx != 0) begin
         sh = 0;
         while ((mx >> sh) >= (64'd1 << 30)) sh++;
         q = 0;
         for (int k = 0; k < 3; k++) begin
            a[k] >>= sh;
            q += a[k] * a[k];
         end
         len = int_sqrt(q);
         for (int k = 0; k < 3; k++) begin
            r = (a[k] * 32768 + len) / (2 * len);
            if (fan_sum[k] > 0) r = -r;
            if (k == 0) res.nx = r[15:0];
            else if (k == 1) res.ny = r[15:0];
            else res.nz = r[15:0];
         end
      end
      res.vis  = seen_visible;
      res.few  = vert_count < 3;
      res.many = vert_count > MaxVerts;
      clear_polygon();
      return 1'b1;
   endfunction

   // offer one vertex and hold it until taken; valid stays high between items unless a random idle gap is drawn
   task automatic offer_vertex(logic [PosW-1:0] px, logic [PosW-1:0] py,
                               logic [PosW-1:0] pz, bit last,
                               bit typed = 1'b0,
                               face_normal_type typed_res = '{default: 0});
      face_normal_type res;
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_pos_x       <= px;
      req_pos_y       <= py;
      req_pos_z       <= pz;
      req_last_vertex <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (predict_vertex(px, py, pz, last, res))
         pending_normals.insert(pending_normals.size(), typed ? typed_res : res);
   endtask

   task automatic drain_and_settle();
      req_valid <= 1'b0;
      while (pending_normals.size() != 0) @(posedge clock);
      repeat (SettleCyc) @(posedge clock);
   endtask

   task automatic write_threshold(logic [CfgWidth-1:0] v);
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      threshold = v;
   endtask

   function automatic logic [PosW-1:0] random_pos(int scale);
      case (scale)
         0: return PosW'($signed($urandom_range(0, 128)) - 64);
         1: return PosW'($signed($urandom_range(0, 16383)) - 8192);
         default: return PosW'($urandom);
      endcase
   endfunction

   task automatic send_polygon(int n_verts, bit noisy);
      int scale;
      scale = $urandom_range(2);
      for (int v = 0; v < n_verts; v++)
         offer_vertex(random_pos(scale), random_pos(scale), random_pos(scale),
                      noisy ? ($urandom_range(7) == 0) || v == n_verts - 1
                            : v == n_verts - 1);
   endtask

   vertex_row_type  directed[$];
   face_normal_type zero_few, up_vis, up_dim, flat;
   int              sent;
   int              size;

   initial begin
      zero_few = '{nx: 0, ny: 0, nz: 0, vis: 0, few: 1, many: 0};
      up_vis   = '{nx: 0, ny: 0, nz: -16'sd16384, vis: 1, few: 0, many: 0};
      up_dim   = '{nx: 0, ny: 0, nz: -16'sd16384, vis: 0, few: 0, many: 0};
      flat     = '{nx: 0, ny: 0, nz: 0, vis: 0, few: 0, many: 0};
      directed = '{
         // lone vertex, then a two-vertex polygon: no triangle
         '{24'h7FFFFF, 24'h800000, 24'h000000, 1, 1, zero_few},
         '{24'h000001, 24'hFFFFFF, 24'h123456, 0, 0, flat},
         '{24'h800000, 24'h7FFFFF, 24'hABCDEF, 1, 1, zero_few},
         // square corner in xy with side 0x1000, large cross
         '{24'h000000, 24'h000000, 24'h000000, 0, 0, flat},
         '{24'h001000, 24'h000000, 24'h000000, 0, 0, flat},
         '{24'h000000, 24'h001000, 24'h000000, 1, 1, up_vis},
         // smallest triangle, below the reset threshold
         '{24'h000000, 24'h000000, 24'h000000, 0, 0, flat},
         '{24'h000001, 24'h000000, 24'h000000, 0, 0, flat},
         '{24'h000000, 24'h000001, 24'h000000, 1, 1, up_dim},
         // collinear points: zero sum
         '{24'h000010, 24'h000010, 24'h000010, 0, 0, flat},
         '{24'h000020, 24'h000020, 24'h000020, 0, 0, flat},
         '{24'h000030, 24'h000030, 24'h000030, 1, 1, flat},
         // extreme corners of the position range
         '{24'h800000, 24'h800000, 24'h800000, 0, 0, flat},
         '{24'h7FFFFF, 24'h800000, 24'h7FFFFF, 0, 0, flat},
         '{24'h7FFFFF, 24'h7FFFFF, 24'h800000, 0, 0, flat},
         '{24'h800000, 24'h7FFFFF, 24'h7FFFFF, 0, 0, flat},
         '{24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 1, 0, flat},
         // pentagon-ish fan, mixed signs
         '{24'hFFF000, 24'h000800, 24'h000100, 0, 0, flat},
         '{24'h002000, 24'hFFE000, 24'h000300, 0, 0, flat},
         '{24'h003000, 24'h001000, 24'hFFFF00, 0, 0, flat},
         '{24'h000000, 24'h004000, 24'h000200, 0, 0, flat},
         '{24'hFFD000, 24'h001800, 24'h000000, 1, 0, flat}
      };

      threshold = CfgReset;
      clear_polygon();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i])
         offer_vertex(directed[i].x, directed[i].y, directed[i].z, directed[i].last,
                      directed[i].typed, directed[i].res);
      drain_and_settle();

      // vertex count limit: exactly at, then beyond it
      write_threshold('0);
      send_polygon(MaxVerts, 0);
      send_polygon(MaxVerts + 3, 0);
      drain_and_settle();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin idle_pct = 0;  stall_pct = 0;  write_threshold(ThrMax); end
            1: begin idle_pct = 48; stall_pct = 0;  write_threshold(CfgReset); end
            2: begin idle_pct = 0;  stall_pct = 48; write_threshold(CfgWidth'($urandom)); end
            default: begin
               idle_pct = 28; stall_pct = 28;
               write_threshold({8'($urandom_range(3)), 32'($urandom)});
            end
         endcase
         if (phase == 0) hold_off = 1'b1;
         sent = 0;
         while (sent < 170) begin
            size = ($urandom_range(9) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 8);
            send_polygon(size, $urandom_range(9) == 0);
            sent += size;
         end
         drain_and_settle();
      end

      if (errors == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
